[src/gpbe_pkg.sv]
// Package for the gamepad report to button event decoder.
// Holds the report and event transaction types, button codes and event slot table.
// No dependencies.
package gpbe_pkg;

  // Pad bytes compared for change detection (X, Y, Z1, Z2, Rz)
  localparam int unsigned PAD_BYTES = 5;
  localparam logic [6:0]  HAT_LEN   = 7'd6;

  // Button codes
  localparam logic [3:0] CODE_UP     = 4'd0;
  localparam logic [3:0] CODE_DOWN   = 4'd1;
  localparam logic [3:0] CODE_LEFT   = 4'd2;
  localparam logic [3:0] CODE_RIGHT  = 4'd3;
  localparam logic [3:0] CODE_H1     = 4'd4;
  localparam logic [3:0] CODE_H2     = 4'd5;
  localparam logic [3:0] CODE_H3     = 4'd6;
  localparam logic [3:0] CODE_L1     = 4'd7;
  localparam logic [3:0] CODE_L2     = 4'd8;
  localparam logic [3:0] CODE_L3     = 4'd9;
  localparam logic [3:0] CODE_MENU   = 4'd10;
  localparam logic [3:0] CODE_START  = 4'd11;
  localparam logic [3:0] CODE_SELECT = 4'd12;

  // Axis values that produce events
  localparam logic [7:0] AXIS_LOW    = 8'h00;
  localparam logic [7:0] AXIS_HIGH   = 8'hFF;
  localparam logic [7:0] AXIS_CENTRE = 8'h80;

  // Reset values of the stored report state
  localparam logic [7:0] PAD_RESET  = 8'h0D;
  localparam logic [7:0] AXIS_RESET = 8'hFF;
  localparam logic [7:0] HAT_RESET  = 8'hDE;
  localparam logic [7:0] HAT_MASK   = 8'h0F;

  // Event slots in emission order:
  // X bits 0-5 and 7, Y bits 0-1, horizontal pair, vertical pair, four hat directions
  localparam int unsigned SLOTS = 17;
  localparam int unsigned SL_X      = 0;
  localparam int unsigned SL_Y      = 7;
  localparam int unsigned SL_HORIZ  = 9;
  localparam int unsigned SL_VERT   = 11;
  localparam int unsigned SL_HAT    = 13;

  localparam logic [3:0] SLOT_CODE [SLOTS] = '{
    CODE_H2, CODE_L2, CODE_L1, CODE_H1, CODE_H3, CODE_L3, CODE_MENU,
    CODE_START, CODE_SELECT,
    CODE_LEFT, CODE_RIGHT,
    CODE_UP, CODE_DOWN,
    CODE_UP, CODE_RIGHT, CODE_DOWN, CODE_LEFT
  };

  typedef struct packed {
    logic [6:0] report_len;
    logic [7:0] x_bits;
    logic [7:0] y_bits;
    logic [7:0] z1_axis;
    logic [7:0] z2_axis;
    logic [7:0] rz_axis;
    logic [7:0] hat_byte;
  } rpt_t;

  typedef struct packed {
    logic [3:0] button_code;
    logic       pressed;
    logic       last_event;
  } evt_t;

endpackage

[src/gamepad_report_to_button_events_core.sv]
// Top level of the gamepad report to button event decoder.
// Depends on gpbe_pkg for the transaction types, codes and the event slot table.
//
//   channel | direction | handshake            | payload
//   rpt     | in        | rpt_valid, rpt_stall | rpt_t: length and six report bytes
//   evt     | out       | evt_valid, evt_stall | evt_t: code, pressed, last mark
//
// A report is decoded in the cycle it is accepted into a slot register of up to 17
// pending events; one event a cycle moves from there to the output register while
// evt is not stalled.
// The next report is taken while the final event of the last one moves out.
// Synchronous active-high reset clears the pending slots, the output valid and the
// stored report state. A stall on evt holds the output register and the slots.
module gamepad_report_to_button_events_core
  import gpbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic rpt_valid,
  output logic rpt_stall,
  input  rpt_t rpt,
  output logic evt_valid,
  input  logic evt_stall,
  output evt_t evt
);

  // Stored report state
  logic [7:0] prev_pad [PAD_BYTES];
  logic [7:0] prev_x;
  logic [7:0] prev_y;
  logic [7:0] prev_horiz;
  logic [7:0] prev_vert;
  logic [7:0] prev_hat;

  // Pending event slots
  logic [SLOTS-1:0] pending;
  logic [SLOTS-1:0] pending_next;
  logic [SLOTS-1:0] pressed;

  logic [SLOTS-1:0] new_en;
  logic [SLOTS-1:0] new_pressed;
  logic [SLOTS-1:0] sel;
  logic [3:0]       sel_code;
  logic             sel_pressed;

  logic       accept;
  logic       out_free;
  logic       move;
  logic       len_ok;
  logic       hat_ok;
  logic       pad_chg;
  logic       horiz_chg;
  logic       vert_chg;
  logic       hat_chg;
  logic [7:0] diff_x;
  logic [7:0] diff_y;
  logic [7:0] hat_now;
  logic [7:0] pad_now [PAD_BYTES];

  assign pad_now[0] = rpt.x_bits;
  assign pad_now[1] = rpt.y_bits;
  assign pad_now[2] = rpt.z1_axis;
  assign pad_now[3] = rpt.z2_axis;
  assign pad_now[4] = rpt.rz_axis;

  // Handshake: take a report once at most the last pending event remains and leaves now
  assign out_free  = !evt_valid || !evt_stall;
  assign move      = out_free && (pending != '0);
  assign rpt_stall = !((pending == '0) ||
                       (out_free && ((pending & (pending - 1'b1)) == '0)));
  assign accept    = rpt_valid && !rpt_stall;

  // Decode the report against the stored state
  always_comb begin
    logic same;
    same = 1'b1;
    for (int i = 0; i < PAD_BYTES; i++) begin
      if (pad_now[i] != prev_pad[i]) same = 1'b0;
    end
    len_ok    = rpt.report_len >= 7'(PAD_BYTES);
    hat_ok    = rpt.report_len >= HAT_LEN;
    pad_chg   = len_ok && !same;
    diff_x    = rpt.x_bits ^ prev_x;
    diff_y    = rpt.y_bits ^ prev_y;
    horiz_chg = pad_chg && (rpt.z2_axis != prev_horiz);
    vert_chg  = pad_chg && (rpt.rz_axis != prev_vert);
    hat_now   = rpt.hat_byte & HAT_MASK;
    hat_chg   = hat_ok && (hat_now != prev_hat);

    new_en      = '0;
    new_pressed = '0;

    // Button masks; X bit 6 and Y bits 2-7 are unmapped
    for (int b = 0; b < 6; b++) begin
      new_en[SL_X + b]      = pad_chg && diff_x[b];
      new_pressed[SL_X + b] = rpt.x_bits[b];
    end
    new_en[SL_X + 6]      = pad_chg && diff_x[7];
    new_pressed[SL_X + 6] = rpt.x_bits[7];
    for (int b = 0; b < 2; b++) begin
      new_en[SL_Y + b]      = pad_chg && diff_y[b];
      new_pressed[SL_Y + b] = rpt.y_bits[b];
    end

    // Axis pairs: only full low, full high and centre emit
    if (rpt.z2_axis == AXIS_LOW || rpt.z2_axis == AXIS_HIGH ||
        rpt.z2_axis == AXIS_CENTRE) begin
      new_en[SL_HORIZ]     = horiz_chg;
      new_en[SL_HORIZ + 1] = horiz_chg;
    end
    new_pressed[SL_HORIZ]     = rpt.z2_axis == AXIS_LOW;
    new_pressed[SL_HORIZ + 1] = rpt.z2_axis == AXIS_HIGH;
    if (rpt.rz_axis == AXIS_LOW || rpt.rz_axis == AXIS_HIGH ||
        rpt.rz_axis == AXIS_CENTRE) begin
      new_en[SL_VERT]     = vert_chg;
      new_en[SL_VERT + 1] = vert_chg;
    end
    new_pressed[SL_VERT]     = rpt.rz_axis == AXIS_LOW;
    new_pressed[SL_VERT + 1] = rpt.rz_axis == AXIS_HIGH;

    // Hat: up, right, down, left; a nibble above seven is neutral
    for (int d = 0; d < 4; d++) new_en[SL_HAT + d] = hat_chg;
    new_pressed[SL_HAT]     = hat_now == 8'd0 || hat_now == 8'd1 || hat_now == 8'd7;
    new_pressed[SL_HAT + 1] = hat_now >= 8'd1 && hat_now <= 8'd3;
    new_pressed[SL_HAT + 2] = hat_now >= 8'd3 && hat_now <= 8'd5;
    new_pressed[SL_HAT + 3] = hat_now >= 8'd5 && hat_now <= 8'd7;
  end

  // Pick the earliest pending slot
  always_comb begin
    sel         = pending & (~pending + 1'b1);
    sel_code    = '0;
    sel_pressed = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel[i]) begin
        sel_code    = sel_code | SLOT_CODE[i];
        sel_pressed = sel_pressed | pressed[i];
      end
    end
  end

  // Load new slots on accept, else drop the slot that moved out
  always_comb begin
    pending_next = pending;
    if (accept) begin
      pending_next = new_en;
    end else if (move) begin
      pending_next = pending & ~sel;
    end
  end

  // Slot and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      evt_valid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (out_free) evt_valid <= move;
    end
    if (accept) pressed <= new_pressed;
    if (move) begin
      evt.button_code <= sel_code;
      evt.pressed     <= sel_pressed;
      evt.last_event  <= (pending & ~sel) == '0;
    end
  end

  // Update the stored report state on each accepted report
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAD_BYTES; i++) prev_pad[i] <= PAD_RESET;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_horiz <= AXIS_RESET;
      prev_vert  <= AXIS_RESET;
      prev_hat   <= HAT_RESET;
    end else if (accept) begin
      if (pad_chg) begin
        for (int i = 0; i < PAD_BYTES; i++) prev_pad[i] <= pad_now[i];
        prev_x     <= rpt.x_bits;
        prev_y     <= rpt.y_bits;
        prev_horiz <= rpt.z2_axis;
        prev_vert  <= rpt.rz_axis;
      end
      if (hat_chg) prev_hat <= hat_now;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for gamepad_report_to_button_events_core.
// Holds the clock, reset, report driver, event checker and the tests in one module.
// Depends on gpbe_pkg for the transaction types and button codes.
module tb_top
  import gpbe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Hat positions in the low nibble of the hat byte; anything above NW is neutral
  localparam logic [7:0] HAT_N  = 8'd0;
  localparam logic [7:0] HAT_NE = 8'd1;
  localparam logic [7:0] HAT_E  = 8'd2;
  localparam logic [7:0] HAT_SE = 8'd3;
  localparam logic [7:0] HAT_S  = 8'd4;
  localparam logic [7:0] HAT_SW = 8'd5;
  localparam logic [7:0] HAT_W  = 8'd6;
  localparam logic [7:0] HAT_NW = 8'd7;

  // Button mapping of the X and Y masks; unmapped bits carry a dummy code
  localparam logic [3:0] X_BUTTON [8] = '{CODE_H2, CODE_L2, CODE_L1, CODE_H1,
                                         CODE_H3, CODE_L3, CODE_UP, CODE_MENU};
  localparam logic [7:0] X_MAPPED = 8'b1011_1111;
  localparam logic [3:0] Y_BUTTON [2] = '{CODE_START, CODE_SELECT};
  localparam logic [7:0] Y_MAPPED = 8'b0000_0011;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk;
  logic rst = 1'b1;
  logic rpt_valid = 1'b0;
  logic rpt_stall;
  rpt_t rpt = '0;
  logic evt_valid;
  logic evt_stall = 1'b0;
  evt_t evt;

  // Decoder state as the testbench sees it
  logic [7:0] seen_pad [PAD_BYTES];
  logic [7:0] seen_x;
  logic [7:0] seen_y;
  logic [7:0] seen_horiz;
  logic [7:0] seen_vert;
  logic [7:0] seen_hat;

  evt_t awaited_events[$];
  rpt_t last_report = '0;
  bit idle_on = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  gamepad_report_to_button_events_core DUT (
    .clk(clk),
    .rst(rst),
    .rpt_valid(rpt_valid),
    .rpt_stall(rpt_stall),
    .rpt(rpt),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  task automatic clear_decoder_state();
    for (int i = 0; i < PAD_BYTES; i++) seen_pad[i] = PAD_RESET;
    seen_x = 8'h00;
    seen_y = 8'h00;
    seen_horiz = AXIS_RESET;
    seen_vert = AXIS_RESET;
    seen_hat = HAT_RESET;
  endtask

  task automatic push_event(input logic [3:0] code, input logic down);
    evt_t e;
    e.button_code = code;
    e.pressed = down;
    e.last_event = 1'b0;
    awaited_events.push_back(e);
  endtask

  // Emit a pair for the three recognised axis values; any change is stored
  task automatic axis_pair(input logic [7:0] now, inout logic [7:0] held,
                           input logic [3:0] low_code, input logic [3:0] high_code);
    if (now != held) begin
      if (now == AXIS_LOW) begin
        push_event(low_code, 1'b1);
        push_event(high_code, 1'b0);
      end else if (now == AXIS_HIGH) begin
        push_event(low_code, 1'b0);
        push_event(high_code, 1'b1);
      end else if (now == AXIS_CENTRE) begin
        push_event(low_code, 1'b0);
        push_event(high_code, 1'b0);
      end
      held = now;
    end
  endtask

  // Work out the button events that one accepted report causes
  task automatic decode_report(input rpt_t r);
    logic [7:0] pad [PAD_BYTES];
    logic [7:0] diff;
    logic [7:0] nibble;
    bit changed;
    bit dir_ok;
    int unsigned queued;
    evt_t tail;
    queued = awaited_events.size();
    if (r.report_len >= 7'(PAD_BYTES)) begin
      pad[0] = r.x_bits;
      pad[1] = r.y_bits;
      pad[2] = r.z1_axis;
      pad[3] = r.z2_axis;
      pad[4] = r.rz_axis;
      changed = 1'b0;
      for (int i = 0; i < PAD_BYTES; i++)
        if (pad[i] != seen_pad[i]) changed = 1'b1;

      if (changed) begin
        diff = r.x_bits ^ seen_x;
        for (int b = 0; b < 8; b++)
          if (diff[b] && X_MAPPED[b]) push_event(X_BUTTON[b], r.x_bits[b]);
        seen_x = r.x_bits;
        diff = r.y_bits ^ seen_y;
        for (int b = 0; b < 2; b++)
          if (diff[b] && Y_MAPPED[b]) push_event(Y_BUTTON[b], r.y_bits[b]);
        seen_y = r.y_bits;
        axis_pair(r.z2_axis, seen_horiz, CODE_LEFT, CODE_RIGHT);
        axis_pair(r.rz_axis, seen_vert, CODE_UP, CODE_DOWN);
        for (int i = 0; i < PAD_BYTES; i++) seen_pad[i] = pad[i];
      end

      // Hat only when the report carries the hat byte
      if (r.report_len >= HAT_LEN) begin
        nibble = r.hat_byte & HAT_MASK;
        if (nibble != seen_hat) begin
          dir_ok = (nibble <= HAT_NW);
          push_event(CODE_UP, dir_ok &&
                     (nibble == HAT_N || nibble == HAT_NE || nibble == HAT_NW));
          push_event(CODE_RIGHT, dir_ok && nibble >= HAT_NE && nibble <= HAT_SE);
          push_event(CODE_DOWN, dir_ok && nibble >= HAT_SE && nibble <= HAT_SW);
          push_event(CODE_LEFT, dir_ok && nibble >= HAT_SW && nibble <= HAT_NW);
          seen_hat = nibble;
        end
      end

      // Mark the final event of this report
      if (awaited_events.size() > queued) begin
        tail = awaited_events.pop_back();
        tail.last_event = 1'b1;
        awaited_events.push_back(tail);
      end
    end
  endtask

  // ---------------------------------------------------------------- driving

  // Offer one report, hold it until accepted, then predict its events
  task automatic send_report(input rpt_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rpt_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    rpt_valid <= 1'b1;
    rpt <= r;
    do @(posedge clk); while (rpt_stall);
    last_report = r;
    decode_report(r);
  endtask

  function automatic rpt_t make_report(input logic [6:0] len, input logic [7:0] x,
                                       input logic [7:0] y, input logic [7:0] z1,
                                       input logic [7:0] z2, input logic [7:0] rz,
                                       input logic [7:0] hat);
    rpt_t r;
    r.report_len = len;
    r.x_bits = x;
    r.y_bits = y;
    r.z1_axis = z1;
    r.z2_axis = z2;
    r.rz_axis = rz;
    r.hat_byte = hat;
    return r;
  endfunction

  // Hold, flip one bit, or replace a button mask
  function automatic logic [7:0] pick_mask(input logic [7:0] held);
    case ($urandom_range(0, 3))
      0: return held;
      1: return held ^ (8'd1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  // Favour the axis values that produce events
  function automatic logic [7:0] pick_axis(input logic [7:0] held);
    case ($urandom_range(0, 4))
      0: return held;
      1: return AXIS_LOW;
      2: return AXIS_HIGH;
      3: return AXIS_CENTRE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rpt_t random_report();
    rpt_t r;
    case ($urandom_range(0, 9))
      0: r.report_len = 7'($urandom_range(0, 4));
      1: r.report_len = 7'd5;
      2: r.report_len = 7'd64;
      default: r.report_len = 7'($urandom_range(6, 63));
    endcase
    r.x_bits = pick_mask(last_report.x_bits);
    r.y_bits = pick_mask(last_report.y_bits);
    r.z1_axis = ($urandom_range(0, 1) == 0) ? last_report.z1_axis : 8'($urandom);
    r.z2_axis = pick_axis(last_report.z2_axis);
    r.rz_axis = pick_axis(last_report.rz_axis);
    r.hat_byte = ($urandom_range(0, 2) == 0) ? last_report.hat_byte : 8'($urandom);
    return r;
  endfunction

  // Receiver back-pressure in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      evt_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      evt_stall <= 1'b1;
    end else begin
      evt_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted event with the oldest awaited one
  always @(posedge clk) begin
    evt_t want;
    if (!rst && evt_valid && !evt_stall) begin
      if (awaited_events.size() == 0) begin
        $error("unexpected event: button_code %0d pressed %0b last_event %0b",
               evt.button_code, evt.pressed, evt.last_event);
        error_count++;
      end else begin
        want = awaited_events.pop_front();
        check_field("button_code", 32'(want.button_code), 32'(evt.button_code));
        check_field("pressed", 32'(want.pressed), 32'(evt.pressed));
        check_field("last_event", 32'(want.last_event), 32'(evt.last_event));
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((rpt_valid && !rpt_stall) || (evt_valid && !evt_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // Reports shorter than the pad are dropped
  task automatic test_short_reports();
    send_report(make_report(7'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(make_report(7'd4, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'h00, 8'h00, 8'h03));
  endtask

  // All masks and axes at their extremes, a repeat with no change, then the opposite extremes
  task automatic test_pad_buttons();
    send_report(make_report(7'd5, 8'hFF, 8'hFF, 8'h00, AXIS_LOW, AXIS_LOW, 8'h00));
    send_report(make_report(7'd5, 8'hFF, 8'hFF, 8'h00, AXIS_LOW, AXIS_LOW, 8'h00));
    send_report(make_report(7'd5, 8'h00, 8'h00, 8'hFF, AXIS_HIGH, AXIS_HIGH, 8'h00));
    // unmapped bits alone plus centred axes
    send_report(make_report(7'd5, 8'h40, 8'hFC, 8'hFF, AXIS_CENTRE, AXIS_CENTRE, 8'h00));
  endtask

  // Other axis values are stored silently; Z1 alone changes nothing visible
  task automatic test_axes();
    send_report(make_report(7'd5, 8'h40, 8'hFC, 8'hFF, 8'h37, 8'hC8, 8'h00));
    send_report(make_report(7'd5, 8'h40, 8'hFC, 8'hFF, AXIS_CENTRE, AXIS_CENTRE, 8'h00));
    send_report(make_report(7'd5, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE, 8'h00));
  endtask

  // Every hat direction, neutral values, an unchanged nibble and a missing hat byte
  task automatic test_hat();
    for (int h = 0; h <= HAT_NW; h++)
      send_report(make_report(7'd6, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE,
                              {4'($urandom), 4'(h)}));
    send_report(make_report(7'd6, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE, 8'hA8));
    send_report(make_report(7'd6, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE, 8'h0F));
    send_report(make_report(7'd6, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE, 8'hFF));
    send_report(make_report(7'd5, 8'h40, 8'hFC, 8'h5A, AXIS_CENTRE, AXIS_CENTRE, 8'h03));
    send_report(make_report(7'd64, 8'hBF, 8'h03, 8'h5A, AXIS_LOW, AXIS_HIGH, 8'h03));
    send_report(make_report(7'd63, 8'h00, 8'h00, 8'h00, AXIS_HIGH, AXIS_LOW, 8'hF4));
  endtask

  // Random reports built by holding, flipping or replacing fields of the previous one
  task automatic test_random_reports(input int unsigned count);
    rpt_t r;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      r = random_report();
      send_report(r);
      sent++;
    end
  endtask

  initial begin
    clear_decoder_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    test_short_reports();
    test_pad_buttons();
    test_axes();
    test_hat();
    test_random_reports(300);

    // back to back with no idling on either side
    idle_on = 1'b0;
    test_random_reports(90);
    rpt_valid <= 1'b0;

    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
